@@ hdl/pcpfa_pkg.sv @@
// Shared types and constants for the per-client page frame allocator.
// Used by the channel interfaces, the front end, the back end and the top level.
package pcpfa_pkg;

  localparam int unsigned CLIENTS_DEF = 16;
  localparam int unsigned FRAMES_DEF  = 256;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned CLIENT_W   = 6;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned PAGE_SHIFT = 12;

  // queue word without the frame index, whose width follows FRAMES
  localparam int unsigned ITEM_FIXED_W = 1 + CLIENT_W + ADDR_W + STATUS_W;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_BAD_CLIENT    = 3'd1,
    ST_BAD_ADDRESS   = 3'd2,
    ST_EMPTY         = 3'd3,
    ST_NOT_ALLOCATED = 3'd4
  } status_e;

  typedef enum logic {
    OP_FREE  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_POP
  } back_state_e;

endpackage

@@ hdl/pcpfa_if.sv @@
// Request and response channel interfaces (valid/ready plus payload).
// Depends on pcpfa_pkg for field widths.
interface pcpfa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [pcpfa_pkg::CLIENT_W-1:0]   client;
  logic [pcpfa_pkg::ADDR_W-1:0]     free_address;

  modport source (output valid, op, client, free_address, input ready);
  modport sink   (input valid, op, client, free_address, output ready);
endinterface

interface pcpfa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pcpfa_pkg::STATUS_W-1:0]   status;
  logic [pcpfa_pkg::ADDR_W-1:0]     frame_address;
  logic                             pager_notify;
  logic [pcpfa_pkg::CLIENT_W-1:0]   notify_client;
  logic [pcpfa_pkg::ADDR_W-1:0]     notify_address;

  modport source (output valid, status, frame_address, pager_notify, notify_client,
                  notify_address, input ready);
  modport sink   (input valid, status, frame_address, pager_notify, notify_client,
                  notify_address, output ready);
endinterface

@@ hdl/pcpfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/pcpfa_front.sv @@
// Front end: takes requests, checks client and free address, builds queue words.
// Depends on pcpfa_pkg and pcpfa_req_if.
module pcpfa_front #(
  parameter int unsigned CLIENTS = pcpfa_pkg::CLIENTS_DEF,
  parameter int unsigned FRAMES  = pcpfa_pkg::FRAMES_DEF
) (
  pcpfa_req_if.sink                                              req,
  input  logic [pcpfa_pkg::ADDR_W-1:0]                           pool_base_i,
  input  logic                                                   init_busy_i,
  output logic                                                   q_valid_o,
  output logic [pcpfa_pkg::ITEM_FIXED_W+$clog2(FRAMES)-1:0]      q_data_o,
  input  logic                                                   q_ready_i
);

  localparam int unsigned FIDX_W = $clog2(FRAMES);
  localparam int unsigned PIDX_W = pcpfa_pkg::ADDR_W - pcpfa_pkg::PAGE_SHIFT;

  logic [pcpfa_pkg::ADDR_W:0]     diff;
  logic [PIDX_W-1:0]              page_idx;
  logic                           below_base;
  logic                           misaligned;
  logic                           idx_ok;
  logic                           client_ok;
  pcpfa_pkg::status_e             pre_status;

  assign diff       = {1'b0, req.free_address} - {1'b0, pool_base_i};
  assign below_base = diff[pcpfa_pkg::ADDR_W];
  assign page_idx   = diff[pcpfa_pkg::ADDR_W-1:pcpfa_pkg::PAGE_SHIFT];
  assign misaligned = |req.free_address[pcpfa_pkg::PAGE_SHIFT-1:0];
  assign idx_ok     = page_idx < PIDX_W'(FRAMES);
  assign client_ok  = {1'b0, req.client} < (pcpfa_pkg::CLIENT_W+1)'(CLIENTS);

  always_comb begin
    priority if (!client_ok) begin
      pre_status = pcpfa_pkg::ST_BAD_CLIENT;
    end else if (pcpfa_pkg::op_e'(req.op) == pcpfa_pkg::OP_FREE &&
                 (below_base || misaligned || !idx_ok)) begin
      pre_status = pcpfa_pkg::ST_BAD_ADDRESS;
    end else begin
      pre_status = pcpfa_pkg::ST_OK;
    end
  end

  assign q_data_o  = {req.op, req.client, req.free_address, page_idx[FIDX_W-1:0], pre_status};
  assign q_valid_o = req.valid && !init_busy_i;
  assign req.ready = q_ready_i && !init_busy_i;

endmodule

@@ hdl/pcpfa_queue.sv @@
// Small FIFO between the classifying front end and the executing back end.
// Depends on nothing but its parameters.
module pcpfa_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WIDTH-1:0]  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WIDTH-1:0]  out_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = count_q != CNT_W'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("queue count did not drop on pop");

endmodule

@@ hdl/pcpfa_back.sv @@
// Back end: per-client free lists in RAM, allocate/free execution, result register.
// Depends on pcpfa_pkg, pcpfa_rsp_if and pcpfa_ram.
module pcpfa_back #(
  parameter int unsigned CLIENTS = pcpfa_pkg::CLIENTS_DEF,
  parameter int unsigned FRAMES  = pcpfa_pkg::FRAMES_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic [pcpfa_pkg::ADDR_W-1:0]                       pool_base_i,
  input  logic                                               q_valid_i,
  input  logic [pcpfa_pkg::ITEM_FIXED_W+$clog2(FRAMES)-1:0]  q_data_i,
  output logic                                               q_ready_o,
  output logic                                               init_busy_o,
  pcpfa_rsp_if.source                                        rsp
);

  localparam int unsigned ADDR_W   = pcpfa_pkg::ADDR_W;
  localparam int unsigned CLIENT_W = pcpfa_pkg::CLIENT_W;
  localparam int unsigned STATUS_W = pcpfa_pkg::STATUS_W;
  localparam int unsigned FIDX_W   = $clog2(FRAMES);
  localparam int unsigned CNT_W    = $clog2(FRAMES + 1);
  localparam int unsigned CIDX_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned SLOTS    = CLIENTS * FRAMES;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned ITEM_W   = pcpfa_pkg::ITEM_FIXED_W + FIDX_W;

  // queue head fields
  pcpfa_pkg::op_e       item_op;
  pcpfa_pkg::status_e   item_pre;
  logic [CLIENT_W-1:0]  item_client;
  logic [ADDR_W-1:0]    item_addr;
  logic [FIDX_W-1:0]    item_idx;

  assign item_pre    = pcpfa_pkg::status_e'(q_data_i[STATUS_W-1:0]);
  assign item_idx    = q_data_i[STATUS_W +: FIDX_W];
  assign item_addr   = q_data_i[STATUS_W+FIDX_W +: ADDR_W];
  assign item_client = q_data_i[STATUS_W+FIDX_W+ADDR_W +: CLIENT_W];
  assign item_op     = pcpfa_pkg::op_e'(q_data_i[ITEM_W-1]);

  pcpfa_pkg::back_state_e state_q, state_d;
  logic                   init_busy_q, init_busy_d;
  logic [SLOT_W-1:0]      clr_q, clr_d;

  // per-client {watermark, returned depth}
  logic                   st_we;
  logic [CIDX_W-1:0]      st_waddr, cidx;
  logic [2*CNT_W-1:0]     st_wdata, st_rdata;
  logic [CNT_W-1:0]       wm, dp;
  // allocated map
  logic                   map_we;
  logic [SLOT_W-1:0]      map_waddr, map_raddr;
  logic [0:0]             map_wdata, map_rdata;
  // returned-frame stacks
  logic                   stk_we;
  logic [SLOT_W-1:0]      stk_waddr, stk_raddr;
  logic [FIDX_W-1:0]      stk_rdata;

  logic [SLOT_W-1:0]      client_base;
  logic [FIDX_W-1:0]      frame_sel;
  logic [ADDR_W-1:0]      alloc_addr;
  logic                   out_free, start, pre_ok;

  logic                   result_load;
  pcpfa_pkg::status_e     res_status;
  logic [ADDR_W-1:0]      res_frame_addr, res_naddr;
  logic                   res_notify;
  logic [CLIENT_W-1:0]    res_nclient;

  logic                   rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]    rsp_status_q;
  logic [ADDR_W-1:0]      rsp_frame_q, rsp_naddr_q;
  logic                   rsp_notify_q;
  logic [CLIENT_W-1:0]    rsp_nclient_q;

  assign cidx        = item_client[CIDX_W-1:0];
  assign client_base = SLOT_W'(cidx) * SLOT_W'(FRAMES);
  assign wm          = st_rdata[2*CNT_W-1:CNT_W];
  assign dp          = st_rdata[CNT_W-1:0];
  assign map_raddr   = client_base + SLOT_W'(item_idx);
  assign stk_raddr   = client_base + SLOT_W'(dp - CNT_W'(1));
  assign stk_waddr   = client_base + SLOT_W'(dp);
  assign frame_sel   = (state_q == pcpfa_pkg::BK_POP) ? stk_rdata
                                                      : FIDX_W'(wm - CNT_W'(1));
  assign alloc_addr  = pool_base_i + (ADDR_W'(frame_sel) << pcpfa_pkg::PAGE_SHIFT);

  assign out_free = !rsp_valid_q || rsp.ready;
  assign start    = (state_q == pcpfa_pkg::BK_IDLE) && q_valid_i && !init_busy_q && out_free;
  assign pre_ok   = item_pre == pcpfa_pkg::ST_OK;

  pcpfa_ram #(.WIDTH(2*CNT_W), .DEPTH(CLIENTS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (cidx),
    .rdata_o (st_rdata)
  );

  pcpfa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  pcpfa_ram #(.WIDTH(FIDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (item_idx),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcpfa_pkg::BK_IDLE: begin
        if (start && pre_ok) begin
          state_d = pcpfa_pkg::BK_EXEC;
        end
      end
      pcpfa_pkg::BK_EXEC: begin
        if (item_op == pcpfa_pkg::OP_ALLOC && dp != '0) begin
          state_d = pcpfa_pkg::BK_POP;
        end else begin
          state_d = pcpfa_pkg::BK_IDLE;
        end
      end
      pcpfa_pkg::BK_POP: state_d = pcpfa_pkg::BK_IDLE;
      default:           state_d = pcpfa_pkg::BK_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    st_we          = 1'b0;
    st_waddr       = cidx;
    st_wdata       = st_rdata;
    map_we         = 1'b0;
    map_waddr      = map_raddr;
    map_wdata      = 1'b0;
    stk_we         = 1'b0;
    result_load    = 1'b0;
    q_ready_o      = 1'b0;
    res_status     = pcpfa_pkg::ST_OK;
    res_frame_addr = '0;
    res_notify     = 1'b0;
    res_nclient    = '0;
    res_naddr      = '0;

    if (init_busy_q) begin
      // clearing pass: one map entry per cycle, per-client state on the first CLIENTS entries
      map_we    = 1'b1;
      map_waddr = clr_q;
      if (clr_q < SLOT_W'(CLIENTS)) begin
        st_we    = 1'b1;
        st_waddr = clr_q[CIDX_W-1:0];
        st_wdata = {CNT_W'(FRAMES), CNT_W'(0)};
      end
    end

    unique case (state_q)
      pcpfa_pkg::BK_IDLE: begin
        if (start && !pre_ok) begin
          result_load = 1'b1;
          q_ready_o   = 1'b1;
          res_status  = item_pre;
        end
      end
      pcpfa_pkg::BK_EXEC: begin
        if (item_op == pcpfa_pkg::OP_ALLOC) begin
          if (dp != '0) begin
            st_we    = 1'b1;
            st_wdata = {wm, dp - CNT_W'(1)};
          end else if (wm != '0) begin
            st_we          = 1'b1;
            st_wdata       = {wm - CNT_W'(1), dp};
            map_we         = 1'b1;
            map_waddr      = client_base + SLOT_W'(frame_sel);
            map_wdata      = 1'b1;
            result_load    = 1'b1;
            q_ready_o      = 1'b1;
            res_frame_addr = alloc_addr;
          end else begin
            result_load = 1'b1;
            q_ready_o   = 1'b1;
            res_status  = pcpfa_pkg::ST_EMPTY;
          end
        end else begin
          if (!map_rdata[0] || dp >= CNT_W'(FRAMES)) begin
            result_load = 1'b1;
            q_ready_o   = 1'b1;
            res_status  = pcpfa_pkg::ST_NOT_ALLOCATED;
          end else begin
            map_we      = 1'b1;
            stk_we      = 1'b1;
            st_we       = 1'b1;
            st_wdata    = {wm, dp + CNT_W'(1)};
            result_load = 1'b1;
            q_ready_o   = 1'b1;
            res_notify  = 1'b1;
            res_nclient = item_client;
            res_naddr   = item_addr;
          end
        end
      end
      pcpfa_pkg::BK_POP: begin
        map_we         = 1'b1;
        map_waddr      = client_base + SLOT_W'(frame_sel);
        map_wdata      = 1'b1;
        result_load    = 1'b1;
        q_ready_o      = 1'b1;
        res_frame_addr = alloc_addr;
      end
      default: ;
    endcase
  end

  always_comb begin
    init_busy_d = init_busy_q;
    clr_d       = clr_q;
    if (init_busy_q) begin
      if (clr_q == SLOT_W'(SLOTS - 1)) begin
        init_busy_d = 1'b0;
      end else begin
        clr_d = clr_q + SLOT_W'(1);
      end
    end
    rsp_valid_d = result_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcpfa_pkg::BK_IDLE;
      init_busy_q <= 1'b1;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_busy_q <= init_busy_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      rsp_status_q  <= res_status;
      rsp_frame_q   <= res_frame_addr;
      rsp_notify_q  <= res_notify;
      rsp_nclient_q <= res_nclient;
      rsp_naddr_q   <= res_naddr;
    end
  end

  assign init_busy_o        = init_busy_q;
  assign rsp.valid          = rsp_valid_q;
  assign rsp.status         = rsp_status_q;
  assign rsp.frame_address  = rsp_frame_q;
  assign rsp.pager_notify   = rsp_notify_q;
  assign rsp.notify_client  = rsp_nclient_q;
  assign rsp.notify_address = rsp_naddr_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_load |-> (!rsp_valid_q || rsp.ready))
    else $error("result register overwritten while a word is pending");

  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy_q |-> (!q_ready_o && state_q == pcpfa_pkg::BK_IDLE))
    else $error("item taken during clearing pass");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcpfa_pkg::BK_EXEC || state_q == pcpfa_pkg::BK_POP) |-> q_valid_i)
    else $error("queue head vanished while executing");

endmodule

@@ hdl/per_client_page_frame_allocator_unit.sv @@
// Top level of the per-client page frame allocator: APB register, front end,
// queue and back end. Depends on pcpfa_pkg, pcpfa_if and all pcpfa_* modules.
//
// Usage:
//   req carries one word per request: op (0 free, 1 allocate), client, and
//   free_address. rsp returns exactly one word per request, in order: status,
//   frame_address, and the pager notification fields on a successful free.
//   pool_base_address is written over APB at byte address 0 (64-bit data,
//   low 48 bits used); pready is always high and reads return the register.
// Sequence: a request rejected on client or address loads the result register straight
//   from the queue head; the others pass BK_EXEC, and an allocate served from the
//   returned-frame stack also BK_POP. The back end finishes one request before it takes
//   the next: each executed request reads then writes the per-client state RAM, and a
//   pop needs a second dependent read of the stack RAM.
// Reset: the allocated map and per-client state are cleared by a pass over all
//   CLIENTS*FRAMES map entries (4096 at defaults); req.ready stays low until done.
// Stall: when rsp is not taken the result register holds, the two-word queue
//   keeps taking requests, then req.ready drops.
module per_client_page_frame_allocator_unit #(
  parameter int unsigned CLIENTS = pcpfa_pkg::CLIENTS_DEF,
  parameter int unsigned FRAMES  = pcpfa_pkg::FRAMES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pcpfa_req_if.sink                        req,
  pcpfa_rsp_if.source                      rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcpfa_pkg::APB_AW-1:0]     paddr,
  input  logic [pcpfa_pkg::APB_DW-1:0]     pwdata,
  output logic [pcpfa_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);

  localparam int unsigned ITEM_W = pcpfa_pkg::ITEM_FIXED_W + $clog2(FRAMES);
  localparam int unsigned ADDR_W = pcpfa_pkg::ADDR_W;

  logic [ADDR_W-1:0]                pool_base_q, pool_base_d;
  logic [pcpfa_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                             init_busy;
  logic                             qi_valid, qi_ready, qo_valid, qo_ready;
  logic [ITEM_W-1:0]                qi_data, qo_data;

  // registers sit at 8-byte strides
  assign reg_idx = paddr[pcpfa_pkg::APB_AW-1:3];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == pcpfa_pkg::REG_POOL_BASE) ? pcpfa_pkg::APB_DW'(pool_base_q)
                                                         : '0;

  always_comb begin
    pool_base_d = pool_base_q;
    if (psel && penable && pwrite && reg_idx == pcpfa_pkg::REG_POOL_BASE) begin
      pool_base_d = pwdata[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else begin
      pool_base_q <= pool_base_d;
    end
  end

  pcpfa_front #(.CLIENTS(CLIENTS), .FRAMES(FRAMES)) u_front (
    .req         (req),
    .pool_base_i (pool_base_q),
    .init_busy_i (init_busy),
    .q_valid_o   (qi_valid),
    .q_data_o    (qi_data),
    .q_ready_i   (qi_ready)
  );

  pcpfa_queue #(.WIDTH(ITEM_W), .DEPTH(pcpfa_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qi_valid),
    .in_ready_o  (qi_ready),
    .in_data_i   (qi_data),
    .out_valid_o (qo_valid),
    .out_ready_i (qo_ready),
    .out_data_o  (qo_data)
  );

  pcpfa_back #(.CLIENTS(CLIENTS), .FRAMES(FRAMES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_base_i (pool_base_q),
    .q_valid_i   (qo_valid),
    .q_data_i    (qo_data),
    .q_ready_o   (qo_ready),
    .init_busy_o (init_busy),
    .rsp         (rsp)
  );

endmodule

@@ sim/per_client_page_frame_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for per_client_page_frame_allocator_unit: directed table, then
// random alloc/free traffic per config phase, every response word checked against the table or a model.
// Depends on pcpfa_pkg, pcpfa_if and the allocator RTL.
module per_client_page_frame_allocator_unit_tb;

  localparam int unsigned CLIENTS_N  = pcpfa_pkg::CLIENTS_DEF;
  localparam int unsigned FRAMES_N   = pcpfa_pkg::FRAMES_DEF;
  localparam int unsigned ADDR_W     = pcpfa_pkg::ADDR_W;
  localparam int unsigned CLIENT_W   = pcpfa_pkg::CLIENT_W;
  localparam int unsigned STATUS_W   = pcpfa_pkg::STATUS_W;
  localparam int unsigned PAGE_SHIFT = pcpfa_pkg::PAGE_SHIFT;
  localparam int unsigned APB_AW     = pcpfa_pkg::APB_AW;
  localparam int unsigned APB_DW     = pcpfa_pkg::APB_DW;
  localparam int unsigned REG_IDX_W  = pcpfa_pkg::REG_IDX_W;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_address;
    logic                pager_notify;
    logic [CLIENT_W-1:0] notify_client;
    logic [ADDR_W-1:0]   notify_address;
  } frame_rsp_t;

  typedef struct {
    pcpfa_pkg::op_e      op;
    logic [CLIENT_W-1:0] client;
    logic [ADDR_W-1:0]   addr;
    bit                  typed;
    frame_rsp_t          rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  pcpfa_req_if req_if ();
  pcpfa_rsp_if rsp_if ();

  per_client_page_frame_allocator_unit #(
    .CLIENTS(CLIENTS_N),
    .FRAMES (FRAMES_N)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_if),
    .rsp    (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // allocator model state
  logic [ADDR_W-1:0] pool_base;
  int unsigned fresh_count [CLIENTS_N];
  int unsigned returned_top [CLIENTS_N];
  int unsigned returned_frames [CLIENTS_N][FRAMES_N];
  bit          frame_in_use [CLIENTS_N][FRAMES_N];

  frame_rsp_t expected_rsps [$];
  int mismatches = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 71;

  // base is 0 for the whole table
  dir_row_t dir_rows [24] = '{
    '{pcpfa_pkg::OP_ALLOC, 6'd0, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFF000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd0, 48'hFFFFFFFFFFFF, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFE000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd15, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFF000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd16, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_BAD_CLIENT, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd63, 48'hFF000, 1'b1,
      '{pcpfa_pkg::ST_BAD_CLIENT, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFF001, 1'b1,
      '{pcpfa_pkg::ST_BAD_ADDRESS, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFFF, 1'b1,
      '{pcpfa_pkg::ST_BAD_ADDRESS, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'h100000, 1'b1,
      '{pcpfa_pkg::ST_BAD_ADDRESS, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFFFFFFFFF000, 1'b1,
      '{pcpfa_pkg::ST_BAD_ADDRESS, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_NOT_ALLOCATED, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd1, 48'hFF000, 1'b1,
      '{pcpfa_pkg::ST_NOT_ALLOCATED, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFF000, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b1, 6'd0, 48'hFF000}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFF000, 1'b1,
      '{pcpfa_pkg::ST_NOT_ALLOCATED, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd15, 48'hFF000, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b1, 6'd15, 48'hFF000}},
    '{pcpfa_pkg::OP_ALLOC, 6'd0, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFF000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFE000, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b1, 6'd0, 48'hFE000}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFF000, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b1, 6'd0, 48'hFF000}},
    '{pcpfa_pkg::OP_ALLOC, 6'd0, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFF000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd0, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFE000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd0, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_OK, 48'hFD000, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd63, 48'h0, 1'b1,
      '{pcpfa_pkg::ST_BAD_CLIENT, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd0, 48'hFD000, 1'b0,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_ALLOC, 6'd15, 48'h5A5A5A5A5000, 1'b0,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b0, 6'd0, 48'h0}},
    '{pcpfa_pkg::OP_FREE, 6'd15, 48'hFF000, 1'b0,
      '{pcpfa_pkg::ST_OK, 48'h0, 1'b0, 6'd0, 48'h0}}
  };

  function automatic logic [ADDR_W-1:0] frame_addr_of(input int unsigned frame);
    return pool_base + (ADDR_W'(frame) << PAGE_SHIFT);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic frame_rsp_t predict_frame_op(input pcpfa_pkg::op_e op,
                                                  input logic [CLIENT_W-1:0] c,
                                                  input logic [ADDR_W-1:0] addr);
    frame_rsp_t r;
    logic [ADDR_W-1:0] offs;
    int unsigned frame;
    r = '0;
    r.status = pcpfa_pkg::ST_OK;
    if (c >= CLIENTS_N) begin
      r.status = pcpfa_pkg::ST_BAD_CLIENT;
      return r;
    end
    if (op == pcpfa_pkg::OP_ALLOC) begin
      // returned stack sits on top of the fresh frames
      if (returned_top[c] > 0) begin
        returned_top[c]--;
        frame = returned_frames[c][returned_top[c]];
      end else if (fresh_count[c] > 0) begin
        fresh_count[c]--;
        frame = fresh_count[c];
      end else begin
        r.status = pcpfa_pkg::ST_EMPTY;
        return r;
      end
      frame_in_use[c][frame] = 1'b1;
      r.frame_address = frame_addr_of(frame);
    end else begin
      offs = addr - pool_base;
      if (addr < pool_base || addr[PAGE_SHIFT-1:0] != '0 ||
          (offs >> PAGE_SHIFT) >= FRAMES_N) begin
        r.status = pcpfa_pkg::ST_BAD_ADDRESS;
        return r;
      end
      frame = int'(offs >> PAGE_SHIFT);
      if (!frame_in_use[c][frame]) begin
        r.status = pcpfa_pkg::ST_NOT_ALLOCATED;
        return r;
      end
      frame_in_use[c][frame] = 1'b0;
      returned_frames[c][returned_top[c]] = frame;
      returned_top[c]++;
      r.pager_notify   = 1'b1;
      r.notify_client  = c;
      r.notify_address = addr;
    end
    return r;
  endfunction

  // random frame of client c whose in-use bit matches, or any frame if none does
  function automatic int unsigned pick_frame(input int unsigned c, input bit used);
    int unsigned start;
    int unsigned f;
    start = $urandom_range(FRAMES_N - 1);
    for (int unsigned k = 0; k < FRAMES_N; k++) begin
      f = (start + k) % FRAMES_N;
      if (frame_in_use[c][f] == used) return f;
    end
    return start;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_free_address(input int unsigned c);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 65) return frame_addr_of(pick_frame(c, 1'b1));
    if (k < 75) return frame_addr_of(pick_frame(c, 1'b0));
    if (k < 85) return frame_addr_of($urandom_range(FRAMES_N - 1)) + ADDR_W'($urandom_range(4095, 1));
    if (k < 90) return frame_addr_of(FRAMES_N + $urandom_range(4095));
    if (k < 95) return pool_base - ADDR_W'($urandom_range(1 << 20, 1));
    return rand_addr();
  endfunction

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(idx) << 3;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write the base, poke the unused index, then read the base back
  task automatic set_pool_base(input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, pcpfa_pkg::REG_POOL_BASE, value, rd);
    pool_base = value[ADDR_W-1:0];
    apb_access(1'b1, REG_UNUSED, {16'($urandom), rand_addr()}, rd);
    apb_access(1'b0, pcpfa_pkg::REG_POOL_BASE, '0, rd);
    check_field("pool_base_address readback", pool_base, rd[ADDR_W-1:0]);
  endtask

  task automatic send_word(input pcpfa_pkg::op_e op, input logic [CLIENT_W-1:0] client,
                           input logic [ADDR_W-1:0] addr, input bit typed, input frame_rsp_t want);
    frame_rsp_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.client       <= client;
    req_if.free_address <= addr;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = predict_frame_op(op, client, addr);
    expected_rsps.push_back(typed ? want : predicted);
  endtask

  task automatic drain_rsps();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // response side: check every accepted word, then pick next ready
  initial begin
    frame_rsp_t want;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (expected_rsps.size() == 0) begin
          $error("response word with no request outstanding");
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_if.status));
          check_field("frame_address", want.frame_address, rsp_if.frame_address);
          check_field("pager_notify", ADDR_W'(want.pager_notify), ADDR_W'(rsp_if.pager_notify));
          check_field("notify_client", ADDR_W'(want.notify_client), ADDR_W'(rsp_if.notify_client));
          check_field("notify_address", want.notify_address, rsp_if.notify_address);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int send_pct [4];
    int recv_pct [4];
    int n_items  [4];
    logic [APB_DW-1:0] base_val;
    pcpfa_pkg::op_e op_sel;
    logic [CLIENT_W-1:0] cl;
    logic [ADDR_W-1:0] ad;
    int unsigned hot;
    int unsigned r;
    bit filling;

    send_pct            = '{26, 71, 0, 0};
    recv_pct            = '{71, 26, 0, 0};
    n_items             = '{520, 520, 460, 100};
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = pcpfa_pkg::OP_FREE;
    req_if.client       = '0;
    req_if.free_address = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pool_base           = '0;
    for (int c = 0; c < CLIENTS_N; c++) begin
      fresh_count[c]  = FRAMES_N;
      returned_top[c] = 0;
      for (int f = 0; f < FRAMES_N; f++) begin
        returned_frames[c][f] = 0;
        frame_in_use[c][f]    = 1'b0;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pool_base('0);
    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].client, dir_rows[i].addr, dir_rows[i].typed,
                dir_rows[i].rsp);

    for (int ph = 0; ph < 4; ph++) begin
      drain_rsps();
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      case (ph)
        0: base_val = 64'({$urandom_range(20'hFFFFF), 12'h000});
        // frames above 127 wrap past the top of the address space
        1: base_val = {16'($urandom), 48'hFFFF_FFF8_0000};
        2: base_val = {16'($urandom), rand_addr() & ~48'hFFF};
        default: base_val = '1;
      endcase
      set_pool_base(base_val);
      hot = ph * 4 + $urandom_range(3);
      for (int i = 0; i < n_items[ph]; i++) begin
        if (i == n_items[ph] / 2) drain_rsps();
        // first stretch drains one client's pool so the empty case shows up
        filling = (i < 300);
        if (filling && $urandom_range(99) < 95) begin
          cl = CLIENT_W'(hot);
          op_sel = ($urandom_range(99) < 95) ? pcpfa_pkg::OP_ALLOC : pcpfa_pkg::OP_FREE;
        end else begin
          r = $urandom_range(99);
          if (r < 10) cl = CLIENT_W'($urandom_range(63, CLIENTS_N));
          else if (r < 60) cl = CLIENT_W'(hot);
          else cl = CLIENT_W'($urandom_range(CLIENTS_N - 1));
          op_sel = ($urandom_range(99) < (filling ? 70 : 40)) ? pcpfa_pkg::OP_ALLOC
                                                               : pcpfa_pkg::OP_FREE;
        end
        ad = rand_addr();
        if (op_sel == pcpfa_pkg::OP_FREE) ad = pick_free_address(cl % CLIENTS_N);
        send_word(op_sel, cl, ad, 1'b0, '0);
      end
    end

    drain_rsps();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
